>>> rtl/core/kvhp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvhp_pkg
// Types, character codes and helper functions shared by the key/value header
// parser: token state, result records and the per-character update logic.
// ----------------------------------------------------------------------------
package kvhp_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_KEY,
    PH_KEY_IGN,
    PH_VAL,
    PH_VAL_IGN,
    PH_DATA
  } phase_t;

  // Result kind codes
  typedef enum logic [1:0] {
    KIND_KEY_VALUE,
    KIND_PAYLOAD,
    KIND_OK_END,
    KIND_ERROR_END
  } kind_t;

  // Character codes
  localparam logic [7:0] CH_EQUAL = 8'h3D;  // '='
  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LOW_A = 8'h61;  // 'a'
  localparam logic [7:0] CH_UP_A  = 8'h41;  // 'A'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] KEY_SIGNED_Z = 8'h7A;  // 'z'
  localparam logic [7:0] KEY_SIGNED_H = 8'h48;  // 'H'
  localparam logic [7:0] KEY_SIGNED_V = 8'h56;  // 'V'

  // Token limits and number ranges
  localparam logic [3:0]  TOKEN_MAX           = 4'd11;
  localparam logic [3:0]  UNSIGNED_DIGITS_MAX = 4'd10;
  localparam logic [36:0] SIGNED_LIMIT        = 37'd2147483648;
  localparam logic [36:0] UNSIGNED_LIMIT      = 37'd4294967295;
  localparam logic [32:0] SIGNED_POS_MAX      = 33'd2147483647;

  // Base64 alphabet offsets
  localparam logic [5:0] SEXTET_UPPER_BASE = 6'd0;
  localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
  localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
  localparam logic [5:0] SEXTET_PLUS       = 6'd62;
  localparam logic [5:0] SEXTET_SLASH      = 6'd63;
  localparam logic [5:0] KEY_UPPER_BASE    = 6'd26;

  // Depth of the result queue
  localparam int RESULT_QUEUE_DEPTH = 4;

  // Current token of the key/value section
  typedef struct packed {
    logic [3:0]  len;
    logic [7:0]  first_char;
    logic [32:0] mag;
    logic        neg;
    logic        bad;
  } token_t;

  localparam token_t TOKEN_CLEAR = '0;

  // One result record
  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  key_index;
    logic [31:0] key_value;
    logic [7:0]  payload_byte;
    logic        last_result;
  } result_t;

  // Outcome of closing a value
  typedef struct packed {
    logic    ok;
    logic    emit;
    result_t res;
  } finish_t;

  // Results of one parsed byte, handed to the result queue
  typedef struct packed {
    logic [1:0] n;
    result_t    res0;
    result_t    res1;
  } push_t;

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic key_signed(logic [7:0] k);
    return (k == KEY_SIGNED_Z) || (k == KEY_SIGNED_H) || (k == KEY_SIGNED_V);
  endfunction

  // Append one character to a value token
  function automatic token_t add_value_char(token_t t, logic [7:0] c, logic sgn);
    token_t      n;
    logic [36:0] prod;
    n    = t;
    prod = ({4'd0, t.mag} << 3) + ({4'd0, t.mag} << 1) + {33'd0, c[3:0]};
    if (t.len == 4'd0) begin
      n.first_char = c;
    end
    if ((t.len == 4'd0) && sgn && (c == CH_MINUS)) begin
      n.neg = 1'b1;
    end else if (!is_digit(c)) begin
      n.bad = 1'b1;
    end else if (!t.bad) begin
      n.mag = prod[32:0];
      if (prod > (sgn ? SIGNED_LIMIT : UNSIGNED_LIMIT)) begin
        n.bad = 1'b1;
      end
    end
    n.len = t.len + 4'd1;
    return n;
  endfunction

  // Close a value: check it and build its key/value result
  function automatic finish_t finish_value(token_t t, logic [7:0] key);
    finish_t     f;
    logic [31:0] v;
    f    = '0;
    v    = '0;
    f.ok = 1'b1;
    if ((t.len == 4'd1) && !is_digit(t.first_char)) begin
      v = {24'd0, t.first_char};
    end else if ((t.len == 4'd0) || t.bad) begin
      f.ok = 1'b0;
    end else if (key_signed(key)) begin
      if (t.neg) begin
        v = 32'd0 - t.mag[31:0];
      end else if (t.mag > SIGNED_POS_MAX) begin
        f.ok = 1'b0;
      end else begin
        v = t.mag[31:0];
      end
    end else if (t.len > UNSIGNED_DIGITS_MAX) begin
      f.ok = 1'b0;
    end else begin
      v = t.mag[31:0];
    end
    f.res.kind      = KIND_KEY_VALUE;
    f.res.key_value = v;
    if (key inside {[8'h61:8'h7A]}) begin
      f.emit          = f.ok;
      f.res.key_index = 6'(key - CH_LOW_A);
    end else if (key inside {[8'h41:8'h5A]}) begin
      f.emit          = f.ok;
      f.res.key_index = 6'(key - CH_UP_A) + KEY_UPPER_BASE;
    end
    return f;
  endfunction

  // Base64 character to sextet; bit 6 marks a valid character
  function automatic logic [6:0] sextet_of(logic [7:0] c);
    logic [6:0] s;
    s = '0;
    if (c inside {[8'h41:8'h5A]}) begin
      s = {1'b1, 6'(c - CH_UP_A) + SEXTET_UPPER_BASE};
    end else if (c inside {[8'h61:8'h7A]}) begin
      s = {1'b1, 6'(c - CH_LOW_A) + SEXTET_LOWER_BASE};
    end else if (c inside {[8'h30:8'h39]}) begin
      s = {1'b1, 6'(c - CH_ZERO) + SEXTET_DIGIT_BASE};
    end else if (c == CH_PLUS) begin
      s = {1'b1, SEXTET_PLUS};
    end else if (c == CH_SLASH) begin
      s = {1'b1, SEXTET_SLASH};
    end
    return s;
  endfunction

endpackage

>>> rtl/core/kvhp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvhp_cmd_if / kvhp_res_if
// Valid/ready channels of the parser: command bytes in, result records out.
// ----------------------------------------------------------------------------
interface kvhp_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       final_byte;

  modport source (output valid, in_byte, final_byte, input ready);
  modport sink   (input valid, in_byte, final_byte, output ready);
endinterface

interface kvhp_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [5:0]  key_index;
  logic [31:0] key_value;
  logic [7:0]  payload_byte;
  logic        last_result;

  modport source (output valid, kind, key_index, key_value, payload_byte, last_result,
                  input ready);
  modport sink   (input valid, kind, key_index, key_value, payload_byte, last_result,
                  output ready);
endinterface

>>> rtl/core/key_value_header_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_header_parser_top
// Flow: a byte accepted into the input register is parsed once the queue has
//   room; its results enter the result queue at the edge that parses it.
// Throughput: one byte per cycle while res takes one result per cycle; a
//   byte yields up to two results, so the result queue sets the sustained rate.
// Reset: synchronous; parser returns to the key phase, queue and input
//   register empty. Each final byte also returns the parser to that state.
// ----------------------------------------------------------------------------
module key_value_header_parser_top #(
  parameter int QUEUE_DEPTH = kvhp_pkg::RESULT_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  kvhp_cmd_if.sink   cmd,
  kvhp_res_if.source res
);
  import kvhp_pkg::*;

  logic       stage_v;
  logic [7:0] stage_byte;
  logic       stage_fin;
  logic       room;
  logic       fire;
  push_t      push;

  // Input register: refills in the cycle it is parsed
  assign fire      = stage_v && room;
  assign cmd.ready = !stage_v || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v <= 1'b0;
    end else begin
      stage_v <= (cmd.valid && cmd.ready) || (stage_v && !fire);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      stage_byte <= cmd.in_byte;
      stage_fin  <= cmd.final_byte;
    end
  end

  kvhp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .in_byte    (stage_byte),
    .final_byte (stage_fin),
    .push       (push)
  );

  kvhp_res_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .room (room),
    .res  (res)
  );

endmodule

>>> rtl/core/kvhp_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvhp_parse
// Parser state and combinational byte update. Each fired byte yields up to two
// results: a key value or payload byte, and the end record of a command.
// ----------------------------------------------------------------------------
module kvhp_parse (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  logic [7:0]      in_byte,
  input  logic            final_byte,
  output kvhp_pkg::push_t push
);
  import kvhp_pkg::*;

  phase_t      phase, phase_next, phase_step;
  token_t      tok, tok_next, tok_step;
  logic [7:0]  key_code, key_code_next, key_code_step;
  logic        failed, failed_next, failed_step;
  logic [11:0] sextet_bits, sextet_bits_next, sextet_bits_step;
  logic [3:0]  bit_count, bit_count_next, bit_count_step;

  finish_t     fin_cur;
  finish_t     fin_end;
  logic [6:0]  sx;
  logic [11:0] bits_cat;
  logic [3:0]  cnt6;
  result_t     r_first;
  logic        r_first_v;
  result_t     r_end;
  logic        end_fail;

  // Byte update, then command end handling
  always_comb begin
    phase_step       = phase;
    tok_step         = tok;
    key_code_step    = key_code;
    failed_step      = failed;
    sextet_bits_step = sextet_bits;
    bit_count_step   = bit_count;
    r_first          = '0;
    r_first_v        = 1'b0;
    fin_cur          = finish_value(tok, key_code);
    sx               = sextet_of(in_byte);
    bits_cat         = {sextet_bits[5:0], sx[5:0]};
    cnt6             = bit_count + 4'd6;

    if (!failed) begin
      case (phase)
        PH_KEY: begin
          if (in_byte == CH_EQUAL) begin
            if (tok.len == 4'd1) begin
              key_code_step = tok.first_char;
              phase_step    = PH_VAL;
            end else begin
              phase_step = PH_VAL_IGN;
            end
            tok_step = TOKEN_CLEAR;
          end else if (in_byte == CH_SEMI) begin
            phase_step = PH_DATA;
          end else if (tok.len < TOKEN_MAX) begin
            if (tok.len == 4'd0) begin
              tok_step.first_char = in_byte;
            end
            tok_step.len = tok.len + 4'd1;
          end else begin
            phase_step = PH_KEY_IGN;
            tok_step   = TOKEN_CLEAR;
          end
        end
        PH_KEY_IGN: begin
          if (in_byte == CH_EQUAL) begin
            phase_step = PH_VAL_IGN;
          end else if (in_byte == CH_SEMI) begin
            phase_step = PH_DATA;
          end
        end
        PH_VAL: begin
          if ((in_byte == CH_COMMA) || (in_byte == CH_SEMI)) begin
            if (!fin_cur.ok) begin
              failed_step = 1'b1;
            end else begin
              r_first    = fin_cur.res;
              r_first_v  = fin_cur.emit;
              tok_step   = TOKEN_CLEAR;
              phase_step = (in_byte == CH_SEMI) ? PH_DATA : PH_KEY;
            end
          end else if (tok.len < TOKEN_MAX) begin
            tok_step = add_value_char(tok, in_byte, key_signed(key_code));
          end else begin
            phase_step = PH_VAL_IGN;
            tok_step   = TOKEN_CLEAR;
          end
        end
        PH_VAL_IGN: begin
          if (in_byte == CH_COMMA) begin
            phase_step = PH_KEY_IGN;
          end else if (in_byte == CH_SEMI) begin
            phase_step = PH_DATA;
          end
        end
        default: begin
          // Base64 payload; filler and whitespace are dropped
          if (!(in_byte inside {CH_EQUAL, CH_LF, CH_CR, CH_SPACE})) begin
            if (!sx[6]) begin
              failed_step = 1'b1;
            end else begin
              sextet_bits_step = bits_cat;
              bit_count_step   = cnt6;
              if (cnt6 >= 4'd8) begin
                bit_count_step       = cnt6 - 4'd8;
                r_first              = '0;
                r_first.kind         = KIND_PAYLOAD;
                r_first.payload_byte = 8'(bits_cat >> bit_count_step);
                r_first_v            = 1'b1;
              end
            end
          end
        end
      endcase
    end

    // Command end: close an open value and report ok or error
    fin_end  = finish_value(tok_step, key_code_step);
    end_fail = failed_step;
    if (!failed_step) begin
      if ((phase_step == PH_KEY) || (phase_step == PH_KEY_IGN)) begin
        end_fail = 1'b1;
      end else if (phase_step == PH_VAL) begin
        if (!fin_end.ok) begin
          end_fail = 1'b1;
        end else if (final_byte && fin_end.emit) begin
          r_first   = fin_end.res;
          r_first_v = 1'b1;
        end
      end
    end
    r_end      = '0;
    r_end.kind = end_fail ? KIND_ERROR_END : KIND_OK_END;

    // Results of this byte
    push = '0;
    if (fire) begin
      if (r_first_v) begin
        push.res0 = r_first;
        if (final_byte) begin
          push.n                = 2'd2;
          push.res1             = r_end;
          push.res1.last_result = 1'b1;
        end else begin
          push.n                = 2'd1;
          push.res0.last_result = 1'b1;
        end
      end else if (final_byte) begin
        push.n                = 2'd1;
        push.res0             = r_end;
        push.res0.last_result = 1'b1;
      end
    end

    // Next state; the final byte returns to reset state
    if (final_byte) begin
      phase_next       = PH_KEY;
      tok_next         = TOKEN_CLEAR;
      key_code_next    = '0;
      failed_next      = 1'b0;
      sextet_bits_next = '0;
      bit_count_next   = '0;
    end else begin
      phase_next       = phase_step;
      tok_next         = tok_step;
      key_code_next    = key_code_step;
      failed_next      = failed_step;
      sextet_bits_next = sextet_bits_step;
      bit_count_next   = bit_count_step;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_KEY;
      tok         <= TOKEN_CLEAR;
      key_code    <= '0;
      failed      <= 1'b0;
      sextet_bits <= '0;
      bit_count   <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      tok         <= tok_next;
      key_code    <= key_code_next;
      failed      <= failed_next;
      sextet_bits <= sextet_bits_next;
      bit_count   <= bit_count_next;
    end
  end

  // Checks
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    fire && final_byte |=> (phase == PH_KEY) && !failed && (bit_count == 4'd0))
    else $error("parser state not cleared after command end");

  a_end_always_reported: assert property (@(posedge clk) disable iff (rst)
    fire && final_byte |-> (push.n != 2'd0))
    else $error("final byte produced no end record");

  a_pair_ends_command: assert property (@(posedge clk) disable iff (rst)
    push.n == 2'd2 |-> ((push.res1.kind == KIND_OK_END) || (push.res1.kind == KIND_ERROR_END))
                       && push.res1.last_result && !push.res0.last_result)
    else $error("second result of a byte is not the command end");

endmodule

>>> rtl/core/kvhp_res_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvhp_res_queue
// Shifting result queue: takes up to two records per cycle, presents the
// oldest at entry zero and drops it on each output transfer.
// ----------------------------------------------------------------------------
module kvhp_res_queue #(
  parameter int DEPTH = kvhp_pkg::RESULT_QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  kvhp_pkg::push_t push,
  output logic            room,
  kvhp_res_if.source      res
);
  import kvhp_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  result_t        q      [DEPTH];
  result_t        q_next [DEPTH];
  logic [CW-1:0]  count, count_next;
  logic [CW-1:0]  base;
  logic           pop;

  assign pop  = res.valid && res.ready;
  assign base = count - CW'(pop);
  assign room = base <= CW'(DEPTH - 2);

  // Shift on pop, then write new records behind the kept ones
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      q_next[i] = (pop && (i < DEPTH - 1)) ? q[(i < DEPTH - 1) ? i + 1 : i] : q[i];
      if ((push.n != 2'd0) && (CW'(i) == base)) begin
        q_next[i] = push.res0;
      end
      if ((push.n == 2'd2) && (CW'(i) == base + CW'(1))) begin
        q_next[i] = push.res1;
      end
    end
    count_next = base + CW'(push.n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

  // Output channel
  assign res.valid        = count != '0;
  assign res.kind         = q[0].kind;
  assign res.key_index    = q[0].key_index;
  assign res.key_value    = q[0].key_value;
  assign res.payload_byte = q[0].payload_byte;
  assign res.last_result  = q[0].last_result;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("result queue overfilled");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push.n != 2'd0 |-> room)
    else $error("records pushed without room");

  a_hold_while_stalled: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid && $stable(q[0]))
    else $error("head result changed while stalled");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives command strings into the key/value header parser and checks each
// result against an in-bench model of the parser. Short directed commands
// cover number limits, skipped keys and values, error ends and base64
// payloads. Random commands follow, mostly well formed with random content,
// under random source gaps and sink stalls, including one long sink hold-off
// that backs the block up.
// ----------------------------------------------------------------------------
module testbench;
  import kvhp_pkg::*;

  logic clk;
  logic rst;

  kvhp_cmd_if cmd ();
  kvhp_res_if res ();

  key_value_header_parser_top uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .res(res)
  );

  // Idle modes: 0 none, 1 occasional waits, 2 a uniform random wait each time
  int src_mode;
  int sink_mode;
  int sink_wait;
  int hold_off_cycles;
  int failures;
  int bytes_sent;

  // Expected results, oldest first
  result_t pending_results[$];
  result_t step_results[$];
  logic [7:0] command_bytes[$];

  // Parser state as predicted
  phase_t          ps_phase;
  logic [3:0]      ps_len;
  logic [7:0]      ps_first;
  logic [7:0]      ps_key;
  longint unsigned ps_mag;
  bit              ps_neg;
  bit              ps_bad;
  bit              ps_failed;
  logic [11:0]     ps_bits;
  int              ps_nbits;

  string b64_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Timeout
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int draw_wait(int mode);
    if (mode == 0) begin
      return 0;
    end else if (mode == 1) begin
      return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    end
    return $urandom_range(0, 16);
  endfunction

  // --------------------------------------------------------------------------
  // Parser prediction
  // --------------------------------------------------------------------------
  function automatic void clear_token();
    ps_len   = '0;
    ps_first = '0;
    ps_mag   = 0;
    ps_neg   = 1'b0;
    ps_bad   = 1'b0;
  endfunction

  function automatic void reset_parser();
    ps_phase  = PH_KEY;
    clear_token();
    ps_key    = '0;
    ps_failed = 1'b0;
    ps_bits   = '0;
    ps_nbits  = 0;
  endfunction

  function automatic bit is_decimal(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_ZERO + 8'd9);
  endfunction

  function automatic bit signed_key();
    return (ps_key == KEY_SIGNED_Z) || (ps_key == KEY_SIGNED_H) || (ps_key == KEY_SIGNED_V);
  endfunction

  function automatic void emit_result(kind_t k, logic [5:0] idx, logic [31:0] v,
                                      logic [7:0] pb);
    result_t r;
    r              = '0;
    r.kind         = k;
    r.key_index    = idx;
    r.key_value    = v;
    r.payload_byte = pb;
    step_results.push_back(r);
  endfunction

  function automatic void take_value_char(logic [7:0] c);
    if (ps_len == 0) ps_first = c;
    if ((ps_len == 0) && signed_key() && (c == CH_MINUS)) begin
      ps_neg = 1'b1;
    end else if (!is_decimal(c)) begin
      ps_bad = 1'b1;
    end else if (!ps_bad) begin
      ps_mag = ps_mag * 10 + (c - CH_ZERO);
      if (ps_mag > (signed_key() ? SIGNED_LIMIT : UNSIGNED_LIMIT)) ps_bad = 1'b1;
    end
    ps_len = ps_len + 4'd1;
  endfunction

  // Close the current value; 0 means the command fails
  function automatic bit close_value();
    logic [31:0] v;
    v = '0;
    if ((ps_len == 1) && !is_decimal(ps_first)) begin
      v = {24'd0, ps_first};
    end else if ((ps_len == 0) || ps_bad) begin
      return 1'b0;
    end else if (signed_key()) begin
      if (ps_neg) begin
        v = 32'(64'd0 - ps_mag);
      end else if (ps_mag > SIGNED_POS_MAX) begin
        return 1'b0;
      end else begin
        v = ps_mag[31:0];
      end
    end else if (ps_len > UNSIGNED_DIGITS_MAX) begin
      return 1'b0;
    end else begin
      v = ps_mag[31:0];
    end
    if ((ps_key >= CH_LOW_A) && (ps_key <= CH_LOW_A + 8'd25)) begin
      emit_result(KIND_KEY_VALUE, 6'(ps_key - CH_LOW_A), v, 8'd0);
    end else if ((ps_key >= CH_UP_A) && (ps_key <= CH_UP_A + 8'd25)) begin
      emit_result(KIND_KEY_VALUE, 6'(ps_key - CH_UP_A) + KEY_UPPER_BASE, v, 8'd0);
    end
    return 1'b1;
  endfunction

  function automatic int base64_value(logic [7:0] c);
    if ((c >= CH_UP_A) && (c <= CH_UP_A + 8'd25)) return c - CH_UP_A;
    if ((c >= CH_LOW_A) && (c <= CH_LOW_A + 8'd25)) return c - CH_LOW_A + 26;
    if (is_decimal(c)) return c - CH_ZERO + 52;
    if (c == CH_PLUS) return 62;
    if (c == CH_SLASH) return 63;
    return -1;
  endfunction

  function automatic void payload_char(logic [7:0] c);
    int s;
    if ((c == CH_EQUAL) || (c == CH_LF) || (c == CH_CR) || (c == CH_SPACE)) return;
    s = base64_value(c);
    if (s < 0) begin
      ps_failed = 1'b1;
      return;
    end
    ps_bits  = {ps_bits[5:0], 6'(s)};
    ps_nbits = ps_nbits + 6;
    if (ps_nbits >= 8) begin
      ps_nbits = ps_nbits - 8;
      emit_result(KIND_PAYLOAD, 6'd0, 32'd0, 8'(ps_bits >> ps_nbits));
    end
  endfunction

  // Advance the model by one accepted byte and queue its results
  function automatic void parse_byte(logic [7:0] c, bit fin);
    step_results.delete();
    if (!ps_failed) begin
      case (ps_phase)
        PH_KEY: begin
          if (c == CH_EQUAL) begin
            if (ps_len == 1) begin
              ps_key   = ps_first;
              ps_phase = PH_VAL;
            end else begin
              ps_phase = PH_VAL_IGN;
            end
            clear_token();
          end else if (c == CH_SEMI) begin
            ps_phase = PH_DATA;
          end else if (ps_len < TOKEN_MAX) begin
            if (ps_len == 0) ps_first = c;
            ps_len = ps_len + 4'd1;
          end else begin
            ps_phase = PH_KEY_IGN;
            clear_token();
          end
        end
        PH_KEY_IGN: begin
          if (c == CH_EQUAL) ps_phase = PH_VAL_IGN;
          else if (c == CH_SEMI) ps_phase = PH_DATA;
        end
        PH_VAL: begin
          if ((c == CH_COMMA) || (c == CH_SEMI)) begin
            if (!close_value()) begin
              ps_failed = 1'b1;
            end else begin
              clear_token();
              ps_phase = (c == CH_SEMI) ? PH_DATA : PH_KEY;
            end
          end else if (ps_len < TOKEN_MAX) begin
            take_value_char(c);
          end else begin
            ps_phase = PH_VAL_IGN;
            clear_token();
          end
        end
        PH_VAL_IGN: begin
          if (c == CH_COMMA) ps_phase = PH_KEY_IGN;
          else if (c == CH_SEMI) ps_phase = PH_DATA;
        end
        default: payload_char(c);
      endcase
    end
    // Final byte closes the command
    if (fin) begin
      if (!ps_failed) begin
        if ((ps_phase == PH_KEY) || (ps_phase == PH_KEY_IGN)) ps_failed = 1'b1;
        else if ((ps_phase == PH_VAL) && !close_value()) ps_failed = 1'b1;
      end
      emit_result(ps_failed ? KIND_ERROR_END : KIND_OK_END, 6'd0, 32'd0, 8'd0);
      reset_parser();
    end
    if (step_results.size() > 0) step_results[$].last_result = 1'b1;
    foreach (step_results[i]) pending_results.push_back(step_results[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Result sink: ready driven at the falling edge, stalls counted here
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      res.ready = 1'b0;
      hold_off_cycles = hold_off_cycles - 1;
    end else if (sink_wait > 0) begin
      res.ready = 1'b0;
      sink_wait = sink_wait - 1;
    end else begin
      res.ready = 1'b1;
    end
  end

  // Result check on each transfer
  always @(posedge clk) begin
    result_t exp_res;
    if (!rst && res.valid && res.ready) begin
      sink_wait = draw_wait(sink_mode);
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d with nothing pending", res.kind);
        failures++;
      end else begin
        exp_res = pending_results.pop_front();
        if (res.kind !== exp_res.kind) begin
          $error("kind: expected %0d, actual %0d", exp_res.kind, res.kind);
          failures++;
        end
        if (res.key_index !== exp_res.key_index) begin
          $error("key_index: expected %0d, actual %0d", exp_res.key_index, res.key_index);
          failures++;
        end
        if (res.key_value !== exp_res.key_value) begin
          $error("key_value: expected %h, actual %h", exp_res.key_value, res.key_value);
          failures++;
        end
        if (res.payload_byte !== exp_res.payload_byte) begin
          $error("payload_byte: expected %h, actual %h", exp_res.payload_byte,
                 res.payload_byte);
          failures++;
        end
        if (res.last_result !== exp_res.last_result) begin
          $error("last_result: expected %0d, actual %0d", exp_res.last_result,
                 res.last_result);
          failures++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Byte source
  // --------------------------------------------------------------------------
  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_byte(input logic [7:0] c, input bit fin);
    int gap;
    gap = draw_wait(src_mode);
    if (gap > 0) begin
      cmd.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd.valid      = 1'b1;
    cmd.in_byte    = c;
    cmd.final_byte = fin;
    do @(posedge clk); while (!cmd.ready);
    parse_byte(c, fin);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_command();
    foreach (command_bytes[i]) send_byte(command_bytes[i], i == command_bytes.size() - 1);
  endtask

  task automatic add_text(input string s);
    foreach (s[i]) command_bytes.push_back(s[i]);
  endtask

  task automatic send_text(input string s);
    command_bytes.delete();
    add_text(s);
    send_command();
  endtask

  task automatic drain();
    cmd.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Random command building
  // --------------------------------------------------------------------------
  task automatic add_value(input bit sgn);
    longint v;
    case ($urandom_range(0, 15))
      0: command_bytes.push_back(CH_LOW_A + 8'($urandom_range(0, 25)));
      1: repeat ($urandom_range(12, 14)) command_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      2: ;
      3: add_text($sformatf("%0dq", $urandom_range(0, 99)));
      4: begin
        case ($urandom_range(0, 3))
          0: v = sgn ? -64'sd2147483648 : 64'sd4294967295;
          1: v = sgn ? 64'sd2147483647 : 64'sd4294967296;
          2: v = sgn ? 64'sd2147483648 : 64'sd0;
          default: v = sgn ? -64'sd2147483649 : 64'sd42949672950;
        endcase
        add_text($sformatf("%0d", v));
      end
      5: add_text($sformatf("00%0d", $urandom_range(0, 999)));
      6: add_text($sformatf("-%0d", $urandom_range(0, 9)));
      default: begin
        if (sgn) v = longint'(int'($urandom()) >>> $urandom_range(0, 31));
        else v = longint'($urandom() >> $urandom_range(0, 31));
        add_text($sformatf("%0d", v));
      end
    endcase
  endtask

  task automatic add_key_value();
    int pick;
    logic [7:0] k;
    pick = $urandom_range(0, 19);
    if (pick < 10) begin
      k = ($urandom_range(0, 1) == 1) ? CH_LOW_A + 8'($urandom_range(0, 25))
                                      : CH_UP_A + 8'($urandom_range(0, 25));
      command_bytes.push_back(k);
    end else if (pick < 16) begin
      case ($urandom_range(0, 2))
        0: k = KEY_SIGNED_Z;
        1: k = KEY_SIGNED_H;
        default: k = KEY_SIGNED_V;
      endcase
      command_bytes.push_back(k);
    end else if (pick == 16) begin
      k = CH_ZERO + 8'($urandom_range(0, 9));
      command_bytes.push_back(k);
    end else if (pick == 17) begin
      k = CH_LOW_A;
      repeat ($urandom_range(2, 13)) command_bytes.push_back(CH_LOW_A + 8'($urandom_range(0, 25)));
    end else if (pick == 18) begin
      k = CH_LOW_A;
    end else begin
      // printable key of any kind, kept clear of the separators
      k = 8'($urandom_range(33, 126));
      if ((k == CH_EQUAL) || (k == CH_SEMI) || (k == CH_COMMA)) k = CH_SLASH;
      command_bytes.push_back(k);
    end
    add_text("=");
    add_value((k == KEY_SIGNED_Z) || (k == KEY_SIGNED_H) || (k == KEY_SIGNED_V));
  endtask

  task automatic add_payload();
    repeat ($urandom_range(0, 12)) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: command_bytes.push_back(CH_EQUAL);
          1: command_bytes.push_back(CH_CR);
          2: command_bytes.push_back(CH_LF);
          default: command_bytes.push_back(CH_SPACE);
        endcase
      end else begin
        command_bytes.push_back(b64_chars[$urandom_range(0, 63)]);
      end
    end
  endtask

  // Mostly well-formed commands; noise and corrupted ones unless clean
  task automatic build_random_command(input bit clean);
    int style;
    int nkeys;
    style = clean ? 9 : $urandom_range(0, 9);
    command_bytes.delete();
    if (style == 0) begin
      repeat ($urandom_range(1, 8)) command_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      nkeys = $urandom_range(0, 4);
      for (int k = 0; k < nkeys; k++) begin
        if (k > 0) add_text(",");
        add_key_value();
      end
      if (style == 2) add_text(",");
      if ($urandom_range(0, 2) != 0) begin
        add_text(";");
        add_payload();
      end
      if (command_bytes.size() == 0) command_bytes.push_back(8'($urandom_range(0, 255)));
      if (style == 1) begin
        command_bytes[$urandom_range(0, command_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_number_ranges();
    send_text("z=-2147483648,H=2147483647,b=4294967295,A=0,k=5");
    send_text("V=2147483648");
    send_text("c=4294967296");
    send_text("z=-2147483649");
    send_text("d=01234567890");
    drain();
  endtask

  task automatic test_key_skips();
    send_text("ab=1,=2,q=x,z=-,7=5");
    send_text("a=123456789012,b=3");
    send_text("abcdefghijkl=1,Z=9;QQ");
    drain();
  endtask

  task automatic test_command_errors();
    send_text("a=,");
    send_text("a");
    send_text("a=1,");
    send_text("7=x5");
    command_bytes.delete();
    command_bytes.push_back(8'h00);
    command_bytes.push_back(8'hFF);
    send_command();
    drain();
  endtask

  task automatic test_payload();
    send_text("k=5;TWFu\r\n TQ==");
    send_text(";TW!u,a=1");
    drain();
  endtask

  task automatic test_random_traffic();
    int src_modes[5];
    int sink_modes[5];
    int target;
    src_modes  = '{0, 2, 1, 2, 0};
    sink_modes = '{0, 2, 1, 0, 2};
    for (int p = 0; p < 5; p++) begin
      src_mode  = src_modes[p];
      sink_mode = sink_modes[p];
      target    = bytes_sent + 300;
      while (bytes_sent < target) begin
        build_random_command(1'b0);
        send_command();
      end
      drain();
    end
  endtask

  // Sink holds off while the source keeps offering bytes
  task automatic test_backpressure();
    src_mode  = 0;
    sink_mode = 0;
    hold_off_cycles = 150;
    repeat (8) begin
      build_random_command(1'b1);
      send_command();
    end
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst             = 1'b1;
    cmd.valid       = 1'b0;
    cmd.in_byte     = '0;
    cmd.final_byte  = 1'b0;
    res.ready       = 1'b0;
    src_mode        = 1;
    sink_mode       = 1;
    sink_wait       = 0;
    hold_off_cycles = 0;
    failures        = 0;
    bytes_sent      = 0;
    reset_parser();
    repeat (6) @(negedge clk);
    rst = 1'b0;

    test_number_ranges();
    test_key_skips();
    test_command_errors();
    test_payload();
    test_random_traffic();
    test_backpressure();

    drain();
    repeat (20) @(negedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
